>>> rtl/lobm_pkg.sv
`timescale 1ns / 1ps
package lobm_pkg;

    localparam int ORDER_CAPACITY_DEF = 32;
    localparam int PRICE_WIDTH_DEF    = 16;
    localparam int MAX_TRADES         = 31;
    localparam int TRADE_CNT_W        = $clog2(MAX_TRADES + 1);
    localparam int QUEUE_DEPTH        = 2;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_CANCEL = 2'd1,
        OP_MATCH  = 2'd2,
        OP_QUERY  = 2'd3
    } op_t;

    localparam logic [3:0] KIND_TRADE      = 4'd0;
    localparam logic [3:0] KIND_ADDED      = 4'd1;
    localparam logic [3:0] KIND_DUPLICATE  = 4'd2;
    localparam logic [3:0] KIND_FULL       = 4'd3;
    localparam logic [3:0] KIND_CANCELLED  = 4'd4;
    localparam logic [3:0] KIND_CANCEL_MISS = 4'd5;
    localparam logic [3:0] KIND_QUERY_HIT  = 4'd6;
    localparam logic [3:0] KIND_QUERY_MISS = 4'd7;
    localparam logic [3:0] KIND_DONE       = 4'd8;

    // order categories, {sell, market}
    localparam logic [1:0] CAT_LB = 2'b00;
    localparam logic [1:0] CAT_MB = 2'b01;
    localparam logic [1:0] CAT_LS = 2'b10;
    localparam logic [1:0] CAT_MS = 2'b11;

    typedef struct packed {
        logic valid;
        op_t  op;
    } q_ctl_t;

endpackage

>>> rtl/limit_order_book_matcher.sv
`timescale 1ns / 1ps
// channel | direction | handshake           | payload
// request | in        | in_valid, in_stall   | mode, order_id, is_sell, is_market, limit_price, quantity
// result  | out       | out_valid, out_stall | kind, buy_id, sell_id, trade_price, amount, last
//
// Add, cancel and query: the result is registered after the request is taken, via pop, search and update steps.
// Match: each trade takes a serial slot scan, a decide step and a sell update, plus the scan for done.
// rst_n is asynchronous; it empties the book and the request queue.
// A two-entry queue lets requests enter while the back end works; out_stall holds the result.
module limit_order_book_matcher #(
    parameter int ORDER_CAPACITY = lobm_pkg::ORDER_CAPACITY_DEF,
    parameter int PRICE_WIDTH    = lobm_pkg::PRICE_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [1:0]             mode,
    input  logic [31:0]            order_id,
    input  logic                   is_sell,
    input  logic                   is_market,
    input  logic [PRICE_WIDTH-1:0] limit_price,
    input  logic [31:0]            quantity,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [3:0]             kind,
    output logic [31:0]            buy_id,
    output logic [31:0]            sell_id,
    output logic [PRICE_WIDTH-1:0] trade_price,
    output logic [31:0]            amount,
    output logic                   last
);
    import lobm_pkg::*;

    q_ctl_t                 q_ctl;
    logic                   q_pop;
    logic [31:0]            q_id, q_qty;
    logic                   q_sell, q_market;
    logic [PRICE_WIDTH-1:0] q_price;

    lobm_front #(.PRICE_WIDTH(PRICE_WIDTH)) u_front (
        .clk, .rst_n, .in_valid, .in_stall, .mode, .order_id, .is_sell, .is_market,
        .limit_price, .quantity, .q_ctl, .q_pop, .q_id, .q_sell, .q_market,
        .q_price, .q_qty
    );

    lobm_back #(.ORDER_CAPACITY(ORDER_CAPACITY), .PRICE_WIDTH(PRICE_WIDTH)) u_back (
        .clk, .rst_n, .q_ctl, .q_pop, .q_id, .q_sell, .q_market, .q_price, .q_qty,
        .out_valid, .out_stall, .kind, .buy_id, .sell_id, .trade_price, .amount, .last
    );

endmodule

>>> rtl/lobm_front.sv
`timescale 1ns / 1ps
module lobm_front #(
    parameter int PRICE_WIDTH = lobm_pkg::PRICE_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [1:0]             mode,
    input  logic [31:0]            order_id,
    input  logic                   is_sell,
    input  logic                   is_market,
    input  logic [PRICE_WIDTH-1:0] limit_price,
    input  logic [31:0]            quantity,
    output lobm_pkg::q_ctl_t       q_ctl,
    input  logic                   q_pop,
    output logic [31:0]            q_id,
    output logic                   q_sell,
    output logic                   q_market,
    output logic [PRICE_WIDTH-1:0] q_price,
    output logic [31:0]            q_qty
);
    import lobm_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    op_t                  op_mem   [QUEUE_DEPTH];
    logic [31:0]          id_mem   [QUEUE_DEPTH];
    logic                 sell_mem [QUEUE_DEPTH];
    logic                 mkt_mem  [QUEUE_DEPTH];
    logic [PRICE_WIDTH-1:0] price_mem [QUEUE_DEPTH];
    logic [31:0]          qty_mem  [QUEUE_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;
    op_t              op_dec;

    assign op_dec = op_t'(mode);

    assign in_stall = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign pop      = q_pop && (count_reg != '0);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            op_mem[wr_ptr_reg]    <= op_dec;
            id_mem[wr_ptr_reg]    <= order_id;
            sell_mem[wr_ptr_reg]  <= is_sell;
            mkt_mem[wr_ptr_reg]   <= is_market;
            price_mem[wr_ptr_reg] <= limit_price;
            qty_mem[wr_ptr_reg]   <= quantity;
        end
    end

    assign q_ctl.valid = (count_reg != '0);
    assign q_ctl.op    = op_mem[rd_ptr_reg];
    assign q_id        = id_mem[rd_ptr_reg];
    assign q_sell      = sell_mem[rd_ptr_reg];
    assign q_market    = mkt_mem[rd_ptr_reg];
    assign q_price     = price_mem[rd_ptr_reg];
    assign q_qty       = qty_mem[rd_ptr_reg];

endmodule

>>> rtl/lobm_back.sv
`timescale 1ns / 1ps
module lobm_back #(
    parameter int ORDER_CAPACITY = lobm_pkg::ORDER_CAPACITY_DEF,
    parameter int PRICE_WIDTH    = lobm_pkg::PRICE_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  lobm_pkg::q_ctl_t       q_ctl,
    output logic                   q_pop,
    input  logic [31:0]            q_id,
    input  logic                   q_sell,
    input  logic                   q_market,
    input  logic [PRICE_WIDTH-1:0] q_price,
    input  logic [31:0]            q_qty,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [3:0]             kind,
    output logic [31:0]            buy_id,
    output logic [31:0]            sell_id,
    output logic [PRICE_WIDTH-1:0] trade_price,
    output logic [31:0]            amount,
    output logic                   last
);
    import lobm_pkg::*;

    localparam int CAP   = ORDER_CAPACITY;
    localparam int IDX_W = $clog2(CAP);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_FIND   = 6'b000010,
        S_OP     = 6'b000100,
        S_SCAN   = 6'b001000,
        S_DECIDE = 6'b010000,
        S_SELL   = 6'b100000
    } state_t;

    state_t state_reg;

    // slot store
    logic [CAP-1:0]         slot_valid_reg;
    logic [31:0]            slot_id_reg     [CAP];
    logic [PRICE_WIDTH-1:0] slot_price_reg  [CAP];
    logic [31:0]            slot_rem_reg    [CAP];
    logic                   slot_sell_reg   [CAP];
    logic                   slot_market_reg [CAP];
    logic [31:0]            slot_arrival_reg [CAP];
    logic [31:0]            arrival_reg;

    // latched request
    op_t                    op_reg;
    logic [31:0]            id_reg;
    logic                   sell_reg, market_reg;
    logic [PRICE_WIDTH-1:0] price_reg;
    logic [31:0]            qty_reg;

    logic [IDX_W-1:0]       scan_reg;
    logic                   hit_reg, free_reg;
    logic [TRADE_CNT_W-1:0] trades_reg;

    // best candidates per category
    logic                   cf_reg    [4];
    logic [IDX_W-1:0]       cidx_reg  [4];
    logic [31:0]            cid_reg   [4];
    logic [PRICE_WIDTH-1:0] cprice_reg [4];
    logic [31:0]            crem_reg  [4];
    logic [31:0]            cage_reg  [4];

    logic [IDX_W-1:0]       sell_idx_reg;
    logic [31:0]            sell_rem_reg;

    logic                   out_valid_reg, last_reg;
    logic [3:0]             kind_reg;
    logic [31:0]            buy_id_reg, sell_id_reg, amount_reg;
    logic [PRICE_WIDTH-1:0] price_out_reg;

    logic can_load;
    assign can_load = !out_valid_reg || !out_stall;

    logic out_load;
    assign out_load = ((state_reg == S_OP) || (state_reg == S_DECIDE)) && can_load;

    // parallel id search and free slot search
    logic             hit_any, free_any;
    logic [IDX_W-1:0] hit_idx, free_idx;

    always_comb
    begin
        hit_any  = 1'b0;
        free_any = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        for (int i = CAP - 1; i >= 0; i--)
        begin
            if (slot_valid_reg[i] && slot_id_reg[i] == id_reg)
            begin
                hit_any = 1'b1;
                hit_idx = IDX_W'(i);
            end
            if (!slot_valid_reg[i])
            begin
                free_any = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    // scan slot candidate compare
    logic [1:0]  scan_cat;
    logic [31:0] scan_age;
    logic        scan_better;

    always_comb
    begin
        scan_cat = {slot_sell_reg[scan_reg], slot_market_reg[scan_reg]};
        scan_age = arrival_reg - slot_arrival_reg[scan_reg];
        if (!cf_reg[scan_cat])
            scan_better = 1'b1;
        else if (!scan_cat[0] && slot_price_reg[scan_reg] != cprice_reg[scan_cat])
            scan_better = scan_cat[1] ? (slot_price_reg[scan_reg] < cprice_reg[scan_cat])
                                      : (slot_price_reg[scan_reg] > cprice_reg[scan_cat]);
        else
            scan_better = scan_age > cage_reg[scan_cat];
    end

    // trade decision
    logic                   do_trade;
    logic [1:0]             b_cat, s_cat;
    logic [PRICE_WIDTH-1:0] tp;
    logic [31:0]            amt;

    always_comb
    begin
        do_trade = 1'b1;
        b_cat    = CAT_LB;
        s_cat    = CAT_LS;
        if (cf_reg[CAT_MB] && cf_reg[CAT_LS])
        begin
            b_cat = CAT_MB;
            s_cat = CAT_LS;
        end
        else if (cf_reg[CAT_MS] && cf_reg[CAT_LB])
        begin
            b_cat = CAT_LB;
            s_cat = CAT_MS;
        end
        else if (!(cf_reg[CAT_LB] && cf_reg[CAT_LS] &&
                   cprice_reg[CAT_LB] >= cprice_reg[CAT_LS]))
            do_trade = 1'b0;
        if (trades_reg == TRADE_CNT_W'(MAX_TRADES))
            do_trade = 1'b0;
        tp  = s_cat[0] ? cprice_reg[b_cat] : cprice_reg[s_cat];
        amt = (crem_reg[b_cat] < crem_reg[s_cat]) ? crem_reg[b_cat] : crem_reg[s_cat];
    end

    assign q_pop = (state_reg == S_IDLE) && q_ctl.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            slot_valid_reg <= '0;
            arrival_reg    <= '0;
            out_valid_reg  <= 1'b0;
            trades_reg     <= '0;
            scan_reg       <= '0;
            for (int c = 0; c < 4; c++)
                cf_reg[c] <= 1'b0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_ctl.valid)
                    begin
                        if (q_ctl.op == OP_MATCH)
                        begin
                            trades_reg <= '0;
                            scan_reg   <= '0;
                            for (int c = 0; c < 4; c++)
                                cf_reg[c] <= 1'b0;
                            state_reg <= S_SCAN;
                        end
                        else
                            state_reg <= S_FIND;
                    end
                end
                S_FIND:
                begin
                    scan_reg  <= hit_any ? hit_idx : free_idx;
                    state_reg <= S_OP;
                end
                S_OP:
                begin
                    if (can_load)
                    begin
                        if (op_reg == OP_ADD && !hit_reg && free_reg)
                        begin
                            slot_valid_reg[scan_reg] <= 1'b1;
                            arrival_reg              <= arrival_reg + 1'b1;
                        end
                        if (op_reg == OP_CANCEL && hit_reg)
                            slot_valid_reg[scan_reg] <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                S_SCAN:
                begin
                    if (slot_valid_reg[scan_reg] && scan_better)
                        cf_reg[scan_cat] <= 1'b1;
                    if (scan_reg == IDX_W'(CAP - 1))
                        state_reg <= S_DECIDE;
                    else
                        scan_reg <= scan_reg + 1'b1;
                end
                S_DECIDE:
                begin
                    if (can_load)
                    begin
                        if (do_trade)
                        begin
                            if (crem_reg[b_cat] == amt)
                                slot_valid_reg[cidx_reg[b_cat]] <= 1'b0;
                            state_reg <= S_SELL;
                        end
                        else
                            state_reg <= S_IDLE;
                    end
                end
                S_SELL:
                begin
                    if (sell_rem_reg == '0)
                        slot_valid_reg[sell_idx_reg] <= 1'b0;
                    trades_reg <= trades_reg + 1'b1;
                    scan_reg   <= '0;
                    for (int c = 0; c < 4; c++)
                        cf_reg[c] <= 1'b0;
                    state_reg <= S_SCAN;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            op_reg     <= q_ctl.op;
            id_reg     <= q_id;
            sell_reg   <= q_sell;
            market_reg <= q_market;
            price_reg  <= q_price;
            qty_reg    <= q_qty;
        end
        if (state_reg == S_FIND)
        begin
            hit_reg  <= hit_any;
            free_reg <= free_any;
        end
        if (state_reg == S_OP && can_load)
        begin
            buy_id_reg    <= id_reg;
            sell_id_reg   <= '0;
            price_out_reg <= (op_reg == OP_QUERY && hit_reg) ? slot_price_reg[scan_reg] : '0;
            amount_reg    <= (op_reg == OP_QUERY && hit_reg) ? slot_rem_reg[scan_reg] : '0;
            last_reg      <= 1'b1;
            unique case (op_reg)
                OP_ADD:
                begin
                    if (hit_reg)
                        kind_reg <= KIND_DUPLICATE;
                    else if (!free_reg)
                        kind_reg <= KIND_FULL;
                    else
                    begin
                        kind_reg                   <= KIND_ADDED;
                        slot_id_reg[scan_reg]      <= id_reg;
                        slot_price_reg[scan_reg]   <= price_reg;
                        slot_rem_reg[scan_reg]     <= qty_reg;
                        slot_sell_reg[scan_reg]    <= sell_reg;
                        slot_market_reg[scan_reg]  <= market_reg;
                        slot_arrival_reg[scan_reg] <= arrival_reg;
                    end
                end
                OP_CANCEL: kind_reg <= hit_reg ? KIND_CANCELLED : KIND_CANCEL_MISS;
                OP_QUERY:  kind_reg <= hit_reg ? KIND_QUERY_HIT : KIND_QUERY_MISS;
                default:   kind_reg <= KIND_DONE;
            endcase
        end
        if (state_reg == S_SCAN && slot_valid_reg[scan_reg] && scan_better)
        begin
            cidx_reg[scan_cat]   <= scan_reg;
            cid_reg[scan_cat]    <= slot_id_reg[scan_reg];
            cprice_reg[scan_cat] <= slot_price_reg[scan_reg];
            crem_reg[scan_cat]   <= slot_rem_reg[scan_reg];
            cage_reg[scan_cat]   <= scan_age;
        end
        if (state_reg == S_DECIDE && can_load)
        begin
            if (do_trade)
            begin
                kind_reg                     <= KIND_TRADE;
                buy_id_reg                   <= cid_reg[b_cat];
                sell_id_reg                  <= cid_reg[s_cat];
                price_out_reg                <= tp;
                amount_reg                   <= amt;
                last_reg                     <= 1'b0;
                slot_rem_reg[cidx_reg[b_cat]] <= crem_reg[b_cat] - amt;
                sell_idx_reg                 <= cidx_reg[s_cat];
                sell_rem_reg                 <= crem_reg[s_cat] - amt;
            end
            else
            begin
                kind_reg      <= KIND_DONE;
                buy_id_reg    <= '0;
                sell_id_reg   <= '0;
                price_out_reg <= '0;
                amount_reg    <= '0;
                last_reg      <= 1'b1;
            end
        end
        if (state_reg == S_SELL)
            slot_rem_reg[sell_idx_reg] <= sell_rem_reg;
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign buy_id      = buy_id_reg;
    assign sell_id     = sell_id_reg;
    assign trade_price = price_out_reg;
    assign amount      = amount_reg;
    assign last        = last_reg;

    a_trade_limit: assert property (@(posedge clk) disable iff (!rst_n)
        trades_reg <= TRADE_CNT_W'(MAX_TRADES))
        else $error("trade count over limit");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (state_reg != S_IDLE))
        else $error("request taken without leaving idle");

    a_sell_after_trade: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SELL) |-> (out_valid_reg && kind_reg == KIND_TRADE && !last_reg))
        else $error("sell update without a trade result");

endmodule

>>> dv/limit_order_book_matcher_tb.sv
`timescale 1ns / 1ps
module limit_order_book_matcher_tb;
    import lobm_pkg::*;

    localparam int SLOTS     = 32;
    localparam int PW        = 16;
    localparam int STALL_MAX = 20000;

    typedef struct {
        logic [3:0]    kind;
        logic [31:0]   buy_id;
        logic [31:0]   sell_id;
        logic [PW-1:0] price;
        logic [31:0]   amount;
        logic          last;
    } book_res_t;

    class book_scoreboard;
        bit            live[SLOTS];
        logic [31:0]   ids[SLOTS];
        logic [PW-1:0] prices[SLOTS];
        logic [31:0]   remaining[SLOTS];
        bit            sells[SLOTS];
        bit            markets[SLOTS];
        logic [31:0]   arrivals[SLOTS];
        logic [31:0]   arrival_cnt;
        book_res_t     pending_results[$];
        int            errors;

        function void clear();
            foreach (live[i]) live[i] = 0;
            arrival_cnt = 0;
            errors = 0;
        endfunction

        function int find_order(logic [31:0] id);
            for (int i = 0; i < SLOTS; i++)
                if (live[i] && ids[i] == id) return i;
            return -1;
        endfunction

        function int best_order(bit sell, bit mkt);
            int best;
            logic [31:0] best_age, age;
            bit better;
            best = -1;
            best_age = 0;
            for (int i = 0; i < SLOTS; i++) begin
                if (!live[i] || sells[i] != sell || markets[i] != mkt) continue;
                age = arrival_cnt - arrivals[i];
                if (best < 0) better = 1;
                else if (!mkt && prices[i] != prices[best])
                    better = sell ? prices[i] < prices[best] : prices[i] > prices[best];
                else better = age > best_age;
                if (better) begin
                    best = i;
                    best_age = age;
                end
            end
            return best;
        endfunction

        function void push(logic [3:0] k, logic [31:0] b, logic [31:0] s,
                           logic [PW-1:0] p, logic [31:0] a, logic l);
            book_res_t r;
            r.kind = k; r.buy_id = b; r.sell_id = s;
            r.price = p; r.amount = a; r.last = l;
            pending_results.insert(pending_results.size(), r);
        endfunction

        function void note_request(op_t op, logic [31:0] id, bit sell, bit mkt,
                                   logic [PW-1:0] p, logic [31:0] qty);
            int i, n, mb, ls, ms, lb, b, s;
            logic [31:0] amt;
            logic [PW-1:0] tp;
            case (op)
                OP_ADD: begin
                    if (find_order(id) >= 0) push(KIND_DUPLICATE, id, 0, 0, 0, 1);
                    else begin
                        for (i = 0; i < SLOTS; i++) if (!live[i]) break;
                        if (i >= SLOTS) push(KIND_FULL, id, 0, 0, 0, 1);
                        else begin
                            live[i] = 1; ids[i] = id; prices[i] = p; remaining[i] = qty;
                            sells[i] = sell; markets[i] = mkt; arrivals[i] = arrival_cnt;
                            arrival_cnt++;
                            push(KIND_ADDED, id, 0, 0, 0, 1);
                        end
                    end
                end
                OP_CANCEL: begin
                    i = find_order(id);
                    if (i < 0) push(KIND_CANCEL_MISS, id, 0, 0, 0, 1);
                    else begin
                        live[i] = 0;
                        push(KIND_CANCELLED, id, 0, 0, 0, 1);
                    end
                end
                OP_QUERY: begin
                    i = find_order(id);
                    if (i < 0) push(KIND_QUERY_MISS, id, 0, 0, 0, 1);
                    else push(KIND_QUERY_HIT, id, 0, prices[i], remaining[i], 1);
                end
                default: begin
                    n = 0;
                    while (n < MAX_TRADES) begin
                        mb = best_order(0, 1);
                        ls = best_order(1, 0);
                        ms = best_order(1, 1);
                        lb = best_order(0, 0);
                        if (mb >= 0 && ls >= 0) begin b = mb; s = ls; end
                        else if (ms >= 0 && lb >= 0) begin b = lb; s = ms; end
                        else if (lb >= 0 && ls >= 0 && prices[lb] >= prices[ls]) begin
                            b = lb; s = ls;
                        end
                        else break;
                        amt = remaining[b] < remaining[s] ? remaining[b] : remaining[s];
                        tp = markets[s] ? prices[b] : prices[s];
                        push(KIND_TRADE, ids[b], ids[s], tp, amt, 0);
                        n++;
                        remaining[b] -= amt;
                        remaining[s] -= amt;
                        if (remaining[b] == 0) live[b] = 0;
                        if (remaining[s] == 0) live[s] = 0;
                    end
                    push(KIND_DONE, 0, 0, 0, 0, 1);
                end
            endcase
        endfunction

        function void check_result(book_res_t got);
            book_res_t want;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result kind %0d", $time, got.kind);
                errors++;
                return;
            end
            want = pending_results[0];
            pending_results.delete(0);
            if (got.kind !== want.kind) begin
                $display("%0t: kind exp %0d got %0d", $time, want.kind, got.kind);
                errors++;
            end
            if (got.buy_id !== want.buy_id) begin
                $display("%0t: buy_id exp %h got %h", $time, want.buy_id, got.buy_id);
                errors++;
            end
            if (got.sell_id !== want.sell_id) begin
                $display("%0t: sell_id exp %h got %h", $time, want.sell_id, got.sell_id);
                errors++;
            end
            if (got.price !== want.price) begin
                $display("%0t: trade_price exp %h got %h", $time, want.price, got.price);
                errors++;
            end
            if (got.amount !== want.amount) begin
                $display("%0t: amount exp %h got %h", $time, want.amount, got.amount);
                errors++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last exp %0b got %0b", $time, want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_stall;
    logic [1:0]    mode;
    logic [31:0]   order_id;
    logic          is_sell;
    logic          is_market;
    logic [PW-1:0] limit_price;
    logic [31:0]   quantity;
    logic          out_valid;
    logic          out_stall;
    logic [3:0]    kind;
    logic [31:0]   buy_id;
    logic [31:0]   sell_id;
    logic [PW-1:0] trade_price;
    logic [31:0]   amount;
    logic          last;

    book_scoreboard book = new();
    bit calm;
    bit long_hold;
    int quiet_cycles;

    limit_order_book_matcher i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .mode(mode), .order_id(order_id), .is_sell(is_sell), .is_market(is_market),
        .limit_price(limit_price), .quantity(quantity),
        .out_valid(out_valid), .out_stall(out_stall),
        .kind(kind), .buy_id(buy_id), .sell_id(sell_id), .trade_price(trade_price),
        .amount(amount), .last(last)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        book_res_t r;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                r.kind = kind; r.buy_id = buy_id; r.sell_id = sell_id;
                r.price = trade_price; r.amount = amount; r.last = last;
                book.check_result(r);
            end
            if ((out_valid && !out_stall) || (in_valid && !in_stall)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= STALL_MAX) begin
                $display("limit_order_book_matcher regression: fail");
                $finish;
            end
        end
    end

    initial
    begin
        int n;
        out_stall <= 1'b1;
        @(posedge rst_n);
        forever
        begin
            n = long_hold ? 400 : (calm ? 0 : $urandom_range(0, 15));
            long_hold = 0;
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic send_request(op_t op, logic [31:0] id, bit sell, bit mkt,
                                logic [PW-1:0] p, logic [31:0] qty);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        mode <= op;
        order_id <= id;
        is_sell <= sell;
        is_market <= mkt;
        limit_price <= p;
        quantity <= qty;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        book.note_request(op, id, sell, mkt, p, qty);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (book.pending_results.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic send_random();
        int r;
        op_t op;
        logic [31:0] id, qty;
        logic [PW-1:0] p;
        r = $urandom_range(0, 99);
        op = r < 50 ? OP_ADD : r < 65 ? OP_CANCEL : r < 80 ? OP_QUERY : OP_MATCH;
        id = ($urandom_range(0, 15) == 0) ? $urandom() : $urandom_range(0, 40);
        p = ($urandom_range(0, 9) == 0) ? PW'($urandom()) : PW'($urandom_range(90, 110));
        r = $urandom_range(0, 15);
        qty = r == 0 ? 32'd0 : r == 1 ? $urandom() : $urandom_range(1, 20);
        send_request(op, id, $urandom_range(0, 1), $urandom_range(0, 5) == 0, p, qty);
    endtask

    initial
    begin
        book.clear();
        calm = 0;
        long_hold = 0;
        quiet_cycles = 0;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        mode <= OP_ADD;
        order_id <= '0;
        is_sell <= 1'b0;
        is_market <= 1'b0;
        limit_price <= '0;
        quantity <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(OP_QUERY, 32'd5, 0, 0, 0, 0);
        send_request(OP_ADD, 32'hFFFFFFFF, 1, 0, '1, 32'hFFFFFFFF);
        send_request(OP_ADD, 32'hFFFFFFFF, 0, 1, 0, 1);
        send_request(OP_QUERY, 32'hFFFFFFFF, 0, 0, 0, 0);
        send_request(OP_CANCEL, 32'hFFFFFFFF, 0, 0, 0, 0);
        send_request(OP_CANCEL, 32'hFFFFFFFF, 0, 0, 0, 0);
        send_request(OP_QUERY, 32'hFFFFFFFF, 0, 0, 0, 0);
        send_request(OP_ADD, 32'd0, 0, 1, 16'd1234, 32'd5);
        send_request(OP_ADD, 32'd1, 1, 1, 16'd77, 32'd3);
        send_request(OP_MATCH, 0, 0, 0, 0, 0);
        send_request(OP_ADD, 32'd2, 1, 0, 16'd100, 32'd0);
        send_request(OP_MATCH, 0, 0, 0, 0, 0);
        send_request(OP_ADD, 32'd3, 0, 0, 16'd200, 32'd4);
        send_request(OP_MATCH, 0, 0, 0, 0, 0);
        send_request(OP_QUERY, 32'd3, 0, 0, 0, 0);
        send_request(OP_QUERY, 32'd0, 0, 0, 0, 0);
        send_request(OP_CANCEL, 32'd0, 0, 0, 0, 0);
        send_request(OP_CANCEL, 32'd3, 0, 0, 0, 0);
        send_request(OP_MATCH, 0, 0, 0, 0, 0);

        // fill the book and overflow it, then one match hits the trade cap
        send_request(OP_ADD, 32'd100, 0, 0, 16'd500, 32'd1000);
        for (int i = 0; i < SLOTS - 1; i++)
            send_request(OP_ADD, 32'd200 + i, 1, 0, PW'(400 - i % 3), 32'd1);
        send_request(OP_ADD, 32'd999, 0, 0, 16'd1, 32'd1);
        send_request(OP_MATCH, 0, 0, 0, 0, 0);
        send_request(OP_MATCH, 0, 0, 0, 0, 0);
        send_request(OP_CANCEL, 32'd100, 0, 0, 0, 0);

        // sender pauses until the book has answered everything
        wait_for_results();

        // receiver holds off while requests keep coming
        long_hold = 1;
        for (int i = 0; i < 20; i++) send_random();

        for (int i = 0; i < 375; i++)
        begin
            calm = (i >= 150 && i < 200);
            send_random();
        end
        calm = 0;

        wait_for_results();
        repeat (200) @(posedge clk);
        if (book.errors == 0 && book.pending_results.size() == 0)
            $display("limit_order_book_matcher regression: pass");
        else
            $display("limit_order_book_matcher regression: fail");
        $finish;
    end
endmodule

>>> files.f
rtl/lobm_pkg.sv
rtl/lobm_front.sv
rtl/lobm_back.sv
rtl/limit_order_book_matcher.sv
dv/limit_order_book_matcher_tb.sv
